@@ rtl/core/bgre_pkg.sv @@
`default_nettype none

package bgre_pkg;

  // Field widths fixed by the item formats.
  localparam int IDX_W = 6;
  localparam int CNT_W = 7;
  localparam int STEP_W = 4;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Kinds of control word.
  localparam logic [1:0] K_WAIT = 2'd0;
  localparam logic [1:0] K_INIT = 2'd1;
  localparam logic [1:0] K_SCAN = 2'd2;
  localparam logic [1:0] K_EMIT = 2'd3;

  // Destination of a finished scan count.
  localparam logic [1:0] DST_DOWN  = 2'd0;
  localparam logic [1:0] DST_UP    = 2'd1;
  localparam logic [1:0] DST_RIGHT = 2'd2;
  localparam logic [1:0] DST_LEFT  = 2'd3;

  // Program steps.
  localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] S_DN_INIT = 4'd1;
  localparam logic [STEP_W-1:0] S_DN_SCAN = 4'd2;
  localparam logic [STEP_W-1:0] S_UP_INIT = 4'd3;
  localparam logic [STEP_W-1:0] S_UP_SCAN = 4'd4;
  localparam logic [STEP_W-1:0] S_RT_INIT = 4'd5;
  localparam logic [STEP_W-1:0] S_RT_SCAN = 4'd6;
  localparam logic [STEP_W-1:0] S_LF_INIT = 4'd7;
  localparam logic [STEP_W-1:0] S_LF_SCAN = 4'd8;
  localparam logic [STEP_W-1:0] S_HIT     = 4'd9;
  localparam logic [STEP_W-1:0] S_MISS    = 4'd10;

  // One control word of the program.
  typedef struct packed {
    logic [1:0]        kind;
    logic              vert;
    logic              dec;
    logic [1:0]        dst;
    logic              found;
    logic              zchk;
    logic [STEP_W-1:0] nxt;
    logic [STEP_W-1:0] jmp;
  } ctl_t;

  // Status returned by the datapath to the sequencer.
  typedef struct packed {
    logic acc_query;
    logic acc_miss;
    logic scan_done;
    logic cnt_zero;
    logic emit_ok;
  } st_t;

  // Program ROM: the wait step jumps to the miss report for queries outside
  // the area, and the first scan jumps there when the queried cell is clear.
  function automatic ctl_t ctl_rom(input logic [STEP_W-1:0] step);
    ctl_t cw;
    cw = '{kind: K_WAIT, vert: 1'b0, dec: 1'b0, dst: DST_DOWN, found: 1'b0,
           zchk: 1'b0, nxt: S_DN_INIT, jmp: S_MISS};
    case (step)
      S_DN_INIT: begin
        cw.kind = K_INIT; cw.vert = 1'b1; cw.nxt = S_DN_SCAN;
      end
      S_DN_SCAN: begin
        cw.kind = K_SCAN; cw.vert = 1'b1; cw.dst = DST_DOWN; cw.zchk = 1'b1;
        cw.nxt = S_UP_INIT; cw.jmp = S_MISS;
      end
      S_UP_INIT: begin
        cw.kind = K_INIT; cw.vert = 1'b1; cw.dec = 1'b1; cw.nxt = S_UP_SCAN;
      end
      S_UP_SCAN: begin
        cw.kind = K_SCAN; cw.vert = 1'b1; cw.dec = 1'b1; cw.dst = DST_UP;
        cw.nxt = S_RT_INIT;
      end
      S_RT_INIT: begin
        cw.kind = K_INIT; cw.nxt = S_RT_SCAN;
      end
      S_RT_SCAN: begin
        cw.kind = K_SCAN; cw.dst = DST_RIGHT; cw.nxt = S_LF_INIT;
      end
      S_LF_INIT: begin
        cw.kind = K_INIT; cw.dec = 1'b1; cw.nxt = S_LF_SCAN;
      end
      S_LF_SCAN: begin
        cw.kind = K_SCAN; cw.dec = 1'b1; cw.dst = DST_LEFT; cw.nxt = S_HIT;
      end
      S_HIT: begin
        cw.kind = K_EMIT; cw.found = 1'b1; cw.nxt = S_IDLE;
      end
      S_MISS: begin
        cw.kind = K_EMIT; cw.nxt = S_IDLE;
      end
      default: begin
        cw.kind = K_WAIT; cw.nxt = S_DN_INIT; cw.jmp = S_MISS;
      end
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bgre_in_if.sv @@
`default_nettype none

// Input channel: one map write or one query per transaction.
interface bgre_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [5:0] row;
  logic [5:0] col;
  logic       cell_value;

  modport source(output valid, output mode, output row, output col,
                 output cell_value, input ready);
  modport sink(input valid, input mode, input row, input col,
               input cell_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bgre_out_if.sv @@
`default_nettype none

// Result channel: one region report per query transaction.
interface bgre_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [6:0] height;
  logic [6:0] width;
  logic [5:0] top_row;
  logic [5:0] left_col;

  modport source(output valid, output found, output height, output width,
                 output top_row, output left_col, input ready);
  modport sink(input valid, input found, input height, input width,
               input top_row, input left_col, output ready);
endinterface

`default_nettype wire

@@ rtl/core/bgre_ram.sv @@
`default_nettype none

// Simple dual-port RAM with registered read.
module bgre_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/bgre_seq.sv @@
`default_nettype none

// Step counter and program ROM; branches on datapath status.
module bgre_seq import bgre_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire st_t  st,
  output ctl_t      ctl
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  assign ctl = ctl_rom(step_r);

  // Next step: hold while a wait, scan or emit step is not finished, otherwise follow or jump.
  always_comb begin
    step_nxt = step_r;
    case (ctl.kind)
      K_WAIT: begin
        if (st.acc_query) begin
          step_nxt = st.acc_miss ? ctl.jmp : ctl.nxt;
        end
      end
      K_INIT: begin
        step_nxt = ctl.nxt;
      end
      K_SCAN: begin
        if (st.scan_done) begin
          step_nxt = (ctl.zchk && st.cnt_zero) ? ctl.jmp : ctl.nxt;
        end
      end
      K_EMIT: begin
        if (st.emit_ok) begin
          step_nxt = ctl.nxt;
        end
      end
      default: begin
        step_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bgre_dp.sv @@
`default_nettype none

// Datapath: map memory, scan pointer and counter, run lengths, result register.
module bgre_dp import bgre_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl,
  output st_t                   st,
  input  wire logic [CNT_W-1:0] n_rows,
  input  wire logic [CNT_W-1:0] n_cols,
  bgre_in_if.sink               in_ch,
  bgre_out_if.source            out_ch
);

  localparam int RowAw = $clog2(MAX_ROWS);
  localparam int ColAw = $clog2(MAX_COLS);
  localparam int AddrW = RowAw + ColAw;
  localparam int Depth = 1 << AddrW;

  logic             acc;
  logic             ram_we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic [0:0]       rdata;

  logic [IDX_W-1:0] q_row_r;
  logic [IDX_W-1:0] q_col_r;
  logic [CNT_W-1:0] pos_r;
  logic [CNT_W-1:0] pos_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pend_r;
  logic             pend_nxt;
  logic [CNT_W-1:0] down_r;
  logic [IDX_W-1:0] up_r;
  logic [CNT_W-1:0] right_r;
  logic [IDX_W-1:0] left_r;

  logic             out_valid_r;
  logic             out_found_r;
  logic [CNT_W-1:0] out_height_r;
  logic [CNT_W-1:0] out_width_r;
  logic [IDX_W-1:0] out_top_r;
  logic [IDX_W-1:0] out_left_r;

  logic             is_scan;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] idx;
  logic             in_rng;
  logic             hit;
  logic             stop;
  logic             issue;
  logic             done;
  logic             emit_ok;
  logic             emit_load;

  // Input transaction: a write inside the map goes straight to the map; one outside is dropped.
  assign in_ch.ready = (ctl.kind == K_WAIT);
  assign acc         = in_ch.valid && in_ch.ready;
  assign ram_we      = acc && (in_ch.mode == MODE_WRITE) &&
                       (int'(in_ch.row) < MAX_ROWS) && (int'(in_ch.col) < MAX_COLS);
  assign waddr       = {RowAw'(in_ch.row), ColAw'(in_ch.col)};

  // Scan: one read issued per cycle, the previous read checked in parallel.
  assign is_scan = (ctl.kind == K_SCAN);
  assign lim     = ctl.vert ? n_rows : n_cols;
  assign idx     = ctl.dec ? (pos_r - CNT_W'(1)) : pos_r;
  assign in_rng  = ctl.dec ? (pos_r != '0) : (pos_r < lim);
  assign hit     = is_scan && pend_r && rdata[0];
  assign stop    = pend_r && !rdata[0];
  assign issue   = is_scan && in_rng && !stop;
  assign done    = is_scan && (stop || (!pend_r && !in_rng));
  assign raddr   = ctl.vert ? {RowAw'(idx), ColAw'(q_col_r)}
                            : {RowAw'(q_row_r), ColAw'(idx)};

  always_comb begin
    pos_nxt  = pos_r;
    cnt_nxt  = cnt_r;
    pend_nxt = issue;
    if (ctl.kind == K_INIT) begin
      pos_nxt = {1'b0, (ctl.vert ? q_row_r : q_col_r)};
      cnt_nxt = '0;
    end else if (is_scan) begin
      if (issue) begin
        pos_nxt = ctl.dec ? (pos_r - CNT_W'(1)) : (pos_r + CNT_W'(1));
      end
      if (hit) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // Result register stays until taken; a new one loads once it is free.
  assign emit_ok   = !out_valid_r || out_ch.ready;
  assign emit_load = (ctl.kind == K_EMIT) && emit_ok;

  assign st.acc_query = acc && (in_ch.mode == MODE_QUERY);
  assign st.acc_miss  = ({1'b0, in_ch.row} >= n_rows) || ({1'b0, in_ch.col} >= n_cols);
  assign st.scan_done = done;
  assign st.cnt_zero  = (cnt_r == '0);
  assign st.emit_ok   = emit_ok;

  bgre_ram #(
    .W     (1),
    .DEPTH (Depth)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_ch.cell_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Query operands, scan registers and run lengths.
  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    cnt_r <= cnt_nxt;
    if (st.acc_query) begin
      q_row_r <= in_ch.row;
      q_col_r <= in_ch.col;
    end
    if (done) begin
      case (ctl.dst)
        DST_DOWN:  down_r  <= cnt_r;
        DST_UP:    up_r    <= IDX_W'(cnt_r);
        DST_RIGHT: right_r <= cnt_r;
        DST_LEFT:  left_r  <= IDX_W'(cnt_r);
        default:   down_r  <= cnt_r;
      endcase
    end
  end

  // Result payload; a miss reports all zero.
  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_found_r <= ctl.found;
      if (ctl.found) begin
        out_height_r <= down_r + CNT_W'(up_r);
        out_width_r  <= right_r + CNT_W'(left_r);
        out_top_r    <= q_row_r - up_r;
        out_left_r   <= q_col_r - left_r;
      end else begin
        out_height_r <= '0;
        out_width_r  <= '0;
        out_top_r    <= '0;
        out_left_r   <= '0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.found    = out_found_r;
  assign out_ch.height   = out_height_r;
  assign out_ch.width    = out_width_r;
  assign out_ch.top_row  = out_top_r;
  assign out_ch.left_col = out_left_r;

endmodule

`default_nettype wire

@@ rtl/core/binary_grid_region_extent.sv @@
// A map write is taken while the program waits and leaves it in its wait step. A query outside
// the area goes from the wait step straight to the miss report; a query on a clear cell goes
// there after the downward scan, and any other query runs all four scans before its report.
// Queries are handled one at a time. The four scans share the single read port of the map
// memory at one cell per cycle; a result that is not taken holds the program.
// Reset: synchronous, active low; the configured area returns to 64 x 64, capped at the map
// size, and the program returns to its wait step. Map contents are undefined until written.
`default_nettype none

module binary_grid_region_extent import bgre_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bgre_in_if.sink               in_ch,
  bgre_out_if.source            out_ch,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] RowCap = (MAX_ROWS > 127) ? 7'd127 : CNT_W'(MAX_ROWS);
  localparam logic [CNT_W-1:0] ColCap = (MAX_COLS > 127) ? 7'd127 : CNT_W'(MAX_COLS);

  logic [CNT_W-1:0] rows_cfg_r;
  logic [CNT_W-1:0] cols_cfg_r;
  logic [CNT_W-1:0] n_rows;
  logic [CNT_W-1:0] n_cols;
  ctl_t             ctl;
  st_t              st;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= 7'd64;
      cols_cfg_r <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_idx == CFG_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end
      if (cfg_idx == CFG_COLS) begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  // The area in use never exceeds the map.
  assign n_rows = (rows_cfg_r < RowCap) ? rows_cfg_r : RowCap;
  assign n_cols = (cols_cfg_r < ColCap) ? cols_cfg_r : ColCap;

  bgre_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  bgre_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .st     (st),
    .n_rows (n_rows),
    .n_cols (n_cols),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
